/* rtl/npcs_pkg.sv */
package npcs_pkg;

  // palette storage
  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // field widths
  localparam int CH_W  = 8;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;

  // largest sum of three squared channel differences
  localparam int SUM_MAX = 3 * ((2 ** CH_W) - 1) * ((2 ** CH_W) - 1);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);

  // scan never goes past the depth or past what best_index can name
  localparam int SCAN_MAX = (PALETTE_DEPTH < (2 ** IDX_W)) ? PALETTE_DEPTH : (2 ** IDX_W);

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PEN_LIMIT     = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] PALETTE_COUNT_RESET = CNT_W'(0);
  localparam logic [CNT_W-1:0] PEN_LIMIT_RESET     = CNT_W'(256);

  // request modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // tag that follows an entry down the scan pipeline
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

/* rtl/npcs_ifs.sv */
// request channel: palette writes and colour queries
interface npcs_req_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [npcs_pkg::IDX_W-1:0] entry_index;
  logic [npcs_pkg::CH_W-1:0]  red;
  logic [npcs_pkg::CH_W-1:0]  green;
  logic [npcs_pkg::CH_W-1:0]  blue;

  modport source (output valid, output mode, output entry_index, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input mode, input entry_index, input red,
                  input green, input blue, output ready);
endinterface

// response channel: nearest entry found for one query
interface npcs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [npcs_pkg::IDX_W-1:0] best_index;
  logic                       none_found;

  modport source (output valid, output best_index, output none_found, input ready);
  modport sink   (input valid, input best_index, input none_found, output ready);
endinterface

// register write channel
interface npcs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [npcs_pkg::CFG_IDX_W-1:0]  index;
  logic [npcs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/npcs_dist.sv */
// squared euclidean distance unit, one entry per cycle, registered result
module npcs_dist (
  input  logic                       clk,
  input  logic                       rst,
  input  npcs_pkg::rgb_t             query,
  input  npcs_pkg::rgb_t             entry,
  input  npcs_pkg::tag_t             tag_in,
  output npcs_pkg::tag_t             tag_out,
  output logic [npcs_pkg::SUM_W-1:0] sum
);

  logic [npcs_pkg::CH_W-1:0]   d_r, d_g, d_b;
  logic [2*npcs_pkg::CH_W-1:0] sq_r, sq_g, sq_b;
  logic [npcs_pkg::SUM_W-1:0]  sum_next;

  // absolute channel differences
  assign d_r = (query.red   > entry.red)   ? query.red   - entry.red   : entry.red   - query.red;
  assign d_g = (query.green > entry.green) ? query.green - entry.green : entry.green - query.green;
  assign d_b = (query.blue  > entry.blue)  ? query.blue  - entry.blue  : entry.blue  - query.blue;

  // squares and their sum
  assign sq_r = (2*npcs_pkg::CH_W)'(d_r) * (2*npcs_pkg::CH_W)'(d_r);
  assign sq_g = (2*npcs_pkg::CH_W)'(d_g) * (2*npcs_pkg::CH_W)'(d_g);
  assign sq_b = (2*npcs_pkg::CH_W)'(d_b) * (2*npcs_pkg::CH_W)'(d_b);
  assign sum_next = npcs_pkg::SUM_W'(sq_r) + npcs_pkg::SUM_W'(sq_g)
                  + npcs_pkg::SUM_W'(sq_b);

  // valid flag and payload
  always_ff @(posedge clk) begin
    tag_out.idx <= tag_in.idx;
    sum         <= sum_next;
    if (rst) begin
      tag_out.vld <= 1'b0;
    end else begin
      tag_out.vld <= tag_in.vld;
    end
  end

endmodule

/* rtl/nearest_palette_colour_search.sv */
// Nearest palette colour search.
// req carries words of two kinds. mode 0 stores red/green/blue at entry_index
// in the palette (indices at or past the depth are dropped); it gives no
// response. mode 1 is a query: the block scans entries 0 to n-1,
// n being the least of palette_count, pen_limit and the depth, and returns on
// rsp the first entry with the smallest sum of squared channel differences,
// or none_found when n is zero.
// A query is one pass of the shared distance unit per entry: one entry per
// cycle through the palette read port. rsp.valid rises when the result is
// loaded, and req is ready again in that same cycle, so a new query is taken
// only once the last one has finished.
// req is not ready while a query scans. The response sits in an output register;
// if rsp stalls, writes and a new query are still taken, and that query holds
// its result until the older response is taken.
// cfg is always ready: index 0 is palette_count, index 1 is pen_limit, other
// indices are ignored; write it only while the block is idle.
// Reset clears the registers (palette_count 0, pen_limit 256) and the control
// state; the palette contents are undefined until written.
module nearest_palette_colour_search (
  input  logic       clk,
  input  logic       rst,
  npcs_cfg_if.sink   cfg,
  npcs_req_if.sink   req,
  npcs_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [npcs_pkg::CNT_W-1:0] palette_count;
  logic [npcs_pkg::CNT_W-1:0] pen_limit;
  logic [npcs_pkg::CNT_W-1:0] lim;
  logic [npcs_pkg::CNT_W-1:0] lim_next;
  logic [npcs_pkg::CNT_W-1:0] cnt;

  npcs_pkg::rgb_t pal_mem [npcs_pkg::PALETTE_DEPTH];
  npcs_pkg::rgb_t rd_data;
  npcs_pkg::rgb_t query;
  npcs_pkg::tag_t rd_tag;
  npcs_pkg::tag_t dist_tag;

  logic [npcs_pkg::SUM_W-1:0] dist_sum;
  logic [npcs_pkg::SUM_W-1:0] best_sum;
  logic [npcs_pkg::IDX_W-1:0] best;
  logic                       found;

  logic                       out_valid;
  logic [npcs_pkg::IDX_W-1:0] out_index;
  logic                       out_none;

  logic req_take, wr_en, q_start, issue, pipe_empty, out_load;
  logic [npcs_pkg::ADDR_W-1:0] wr_addr, rd_addr;

  // handshakes
  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign wr_en     = req_take && (req.mode == npcs_pkg::MODE_WRITE)
                   && (32'(req.entry_index) < npcs_pkg::PALETTE_DEPTH);
  assign q_start   = req_take && (req.mode == npcs_pkg::MODE_QUERY);
  assign issue     = (state == ST_SCAN) && (cnt < lim);
  assign pipe_empty = !rd_tag.vld && !dist_tag.vld;
  assign out_load  = (state == ST_FINISH) && (!out_valid || rsp.ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= npcs_pkg::PALETTE_COUNT_RESET;
      pen_limit     <= npcs_pkg::PEN_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == npcs_pkg::REG_PALETTE_COUNT) begin
        palette_count <= npcs_pkg::CNT_W'(cfg.data);
      end else if (cfg.index == npcs_pkg::REG_PEN_LIMIT) begin
        pen_limit <= npcs_pkg::CNT_W'(cfg.data);
      end
    end
  end

  // scan limit at query start
  always_comb begin
    lim_next = palette_count;
    if (pen_limit < lim_next) begin
      lim_next = pen_limit;
    end
    if (npcs_pkg::CNT_W'(npcs_pkg::SCAN_MAX) < lim_next) begin
      lim_next = npcs_pkg::CNT_W'(npcs_pkg::SCAN_MAX);
    end
  end

  // palette memory, one write port and one registered read port
  assign wr_addr = npcs_pkg::ADDR_W'(req.entry_index);
  assign rd_addr = npcs_pkg::ADDR_W'(cnt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[wr_addr] <= '{red: req.red, green: req.green, blue: req.blue};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= pal_mem[rd_addr];
  end

  // read stage tag
  always_ff @(posedge clk) begin
    rd_tag.idx <= npcs_pkg::IDX_W'(cnt);
    if (rst) begin
      rd_tag.vld <= 1'b0;
    end else begin
      rd_tag.vld <= issue;
    end
  end

  // query capture, limit and scan counter
  always_ff @(posedge clk) begin
    if (q_start) begin
      query <= '{red: req.red, green: req.green, blue: req.blue};
      lim   <= lim_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_start) begin
      cnt <= '0;
    end else if (issue) begin
      cnt <= cnt + npcs_pkg::CNT_W'(1);
    end
  end

  // shared distance unit
  npcs_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .query   (query),
    .entry   (rd_data),
    .tag_in  (rd_tag),
    .tag_out (dist_tag),
    .sum     (dist_sum)
  );

  // running minimum, first entry wins ties
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (q_start) begin
      found <= 1'b0;
    end else if (dist_tag.vld && (!found || dist_sum < best_sum)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_tag.vld && (!found || dist_sum < best_sum)) begin
      best_sum <= dist_sum;
      best     <= dist_tag.idx;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index <= found ? best : '0;
      out_none  <= !found;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.best_index = out_index;
  assign rsp.none_found = out_none;

endmodule
